/* src/tun_pkg.sv */
package tun_pkg;

   localparam int CoordBits      = 20;
   localparam int NormalFracBits = 14;
   localparam int OutBits        = 16;

   typedef struct packed {
      logic signed [CoordBits-1:0] first_x;
      logic signed [CoordBits-1:0] first_y;
      logic signed [CoordBits-1:0] first_z;
      logic signed [CoordBits-1:0] second_x;
      logic signed [CoordBits-1:0] second_y;
      logic signed [CoordBits-1:0] second_z;
      logic signed [CoordBits-1:0] third_x;
      logic signed [CoordBits-1:0] third_y;
      logic signed [CoordBits-1:0] third_z;
   } tun_req_type;

   typedef struct packed {
      logic signed [OutBits-1:0] normal_x;
      logic signed [OutBits-1:0] normal_y;
      logic signed [OutBits-1:0] normal_z;
      logic                      degenerate;
   } tun_rsp_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic degen;
   } tun_ctl_type;

endpackage

/* src/tun_cell.sv */
module tun_cell #(
   parameter int RW   = 140,
   parameter int YW   = 104,
   parameter int SUMW = 88,
   parameter int KW   = 16,
   parameter int BIT  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  tun_pkg::tun_ctl_type prev_ctl,
   input  logic [RW-1:0]       prev_r,
   input  logic [YW-1:0]       prev_y,
   input  logic [SUMW-1:0]     prev_s,
   input  logic [KW-1:0]       prev_k,
   output tun_pkg::tun_ctl_type ctl,
   output logic [RW-1:0]       r,
   output logic [YW-1:0]       y,
   output logic [SUMW-1:0]     s,
   output logic [KW-1:0]       k
);

   tun_pkg::tun_ctl_type ctl_ff;
   logic [RW-1:0]   r_ff, r_in, d;
   logic [YW-1:0]   y_ff, y_in;
   logic [SUMW-1:0] s_ff;
   logic [KW-1:0]   k_ff, k_in;
   logic            take;

   always_comb begin
      d    = (RW'(prev_y) << (BIT + 1)) + (RW'(prev_s) << (2 * BIT));
      take = (prev_r >= d);
      r_in = take ? (prev_r - d) : prev_r;
      y_in = take ? (prev_y + (YW'(prev_s) << BIT)) : prev_y;
      k_in = take ? (prev_k | (KW'(1) << BIT)) : prev_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= prev_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in;
         y_ff <= y_in;
         s_ff <= prev_s;
         k_ff <= k_in;
      end
   end

   assign ctl = ctl_ff;
   assign r   = r_ff;
   assign y   = y_ff;
   assign s   = s_ff;
   assign k   = k_ff;

endmodule

/* src/triangle_unit_normal.sv */
// Pipeline: 7 front stages, NORMAL_FRAC_BITS + 2 square-root cells and one output
// register lie between accept and result.
// Throughput: one item per cycle; the whole pipeline holds only while a result
// waits on a stalled output, each cell resolving one bit of the quotient root.
// Reset: synchronous, clears all valid bits; no stored state survives an item.
module triangle_unit_normal #(
   parameter int NORMAL_FRAC_BITS = tun_pkg::NormalFracBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tun_pkg::tun_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tun_pkg::tun_rsp_type rsp_payload
);

   localparam int CB   = tun_pkg::CoordBits;
   localparam int OB   = tun_pkg::OutBits;
   localparam int F    = NORMAL_FRAC_BITS;
   localparam int DW   = CB + 1;
   localparam int PW   = 2 * DW;
   localparam int MW   = PW;
   localparam int H    = MW / 2;
   localparam int HW   = MW - H;
   localparam int SW   = 2 * MW;
   localparam int SUMW = SW + 2;
   localparam int RW   = SUMW + 2 * F + 5;
   localparam int KW   = F + 2;
   localparam int YW   = SUMW + KW;
   localparam int XW   = (KW > OB) ? KW : OB;
   localparam int NC   = F + 2;

   logic                 advance;
   logic [6:0]           v_ff;
   tun_pkg::tun_req_type in_ff;
   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] w_ff [3];
   logic signed [PW-1:0] p_ff [6];
   logic [MW-1:0]        mag_ff [3];
   logic [2*HW-1:0]      hh_ff [3];
   logic [H+HW-1:0]      hl_ff [3];
   logic [2*H-1:0]       ll_ff [3];
   logic [SW-1:0]        sq_ff [3];
   logic [SW-1:0]        sq7_ff [3];
   logic [SUMW-1:0]      s_ff;
   logic [2:0]           neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic                 rsp_valid_ff;
   tun_pkg::tun_rsp_type rsp_payload_ff, rsp_payload_in;
   logic [OB-1:0]        res [3];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[5:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= req_payload;
         u_ff[0] <= $signed({in_ff.second_x[CB-1], in_ff.second_x}
                            - {in_ff.first_x[CB-1], in_ff.first_x});
         u_ff[1] <= $signed({in_ff.second_y[CB-1], in_ff.second_y}
                            - {in_ff.first_y[CB-1], in_ff.first_y});
         u_ff[2] <= $signed({in_ff.second_z[CB-1], in_ff.second_z}
                            - {in_ff.first_z[CB-1], in_ff.first_z});
         w_ff[0] <= $signed({in_ff.third_x[CB-1], in_ff.third_x}
                            - {in_ff.first_x[CB-1], in_ff.first_x});
         w_ff[1] <= $signed({in_ff.third_y[CB-1], in_ff.third_y}
                            - {in_ff.first_y[CB-1], in_ff.first_y});
         w_ff[2] <= $signed({in_ff.third_z[CB-1], in_ff.third_z}
                            - {in_ff.first_z[CB-1], in_ff.first_z});
         p_ff[0] <= PW'(u_ff[1]) * PW'(w_ff[2]);
         p_ff[1] <= PW'(u_ff[2]) * PW'(w_ff[1]);
         p_ff[2] <= PW'(u_ff[2]) * PW'(w_ff[0]);
         p_ff[3] <= PW'(u_ff[0]) * PW'(w_ff[2]);
         p_ff[4] <= PW'(u_ff[0]) * PW'(w_ff[1]);
         p_ff[5] <= PW'(u_ff[1]) * PW'(w_ff[0]);
         neg5_ff <= neg4_ff;
         neg6_ff <= neg5_ff;
         neg7_ff <= neg6_ff;
         s_ff    <= SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [PW:0] c;

      assign c = {p_ff[2*i][PW-1], p_ff[2*i]} - {p_ff[2*i+1][PW-1], p_ff[2*i+1]};

      always_ff @(posedge clock) begin
         if (advance) begin
            neg4_ff[i] <= c[PW];
            mag_ff[i]  <= c[PW] ? MW'(-c) : MW'(c);
            hh_ff[i]   <= (2*HW)'(mag_ff[i][MW-1:H]) * (2*HW)'(mag_ff[i][MW-1:H]);
            hl_ff[i]   <= (H+HW)'(mag_ff[i][MW-1:H]) * (H+HW)'(mag_ff[i][H-1:0]);
            ll_ff[i]   <= (2*H)'(mag_ff[i][H-1:0]) * (2*H)'(mag_ff[i][H-1:0]);
            sq_ff[i]   <= (SW'(hh_ff[i]) << (2 * H)) + (SW'(hl_ff[i]) << (H + 1))
                          + SW'(ll_ff[i]);
            sq7_ff[i]  <= sq_ff[i];
         end
      end

      tun_pkg::tun_ctl_type cc [NC+1];
      logic [RW-1:0]   cr [NC+1];
      logic [YW-1:0]   cy [NC+1];
      logic [SUMW-1:0] cs [NC+1];
      logic [KW-1:0]   ck [NC+1];
      logic [KW:0]     kp1;
      logic [XW-1:0]   nx, rx;

      assign cc[0].valid = v_ff[6];
      assign cc[0].neg   = neg7_ff[i];
      assign cc[0].degen = (s_ff == '0);
      assign cr[0]       = RW'(sq7_ff[i]) << (2 * F + 2);
      assign cy[0]       = '0;
      assign cs[0]       = s_ff;
      assign ck[0]       = '0;

      for (genvar j = 0; j < NC; j++) begin : g_cell
         tun_cell #(
            .RW   (RW),
            .YW   (YW),
            .SUMW (SUMW),
            .KW   (KW),
            .BIT  (NC - 1 - j)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .prev_ctl (cc[j]),
            .prev_r   (cr[j]),
            .prev_y   (cy[j]),
            .prev_s   (cs[j]),
            .prev_k   (ck[j]),
            .ctl      (cc[j+1]),
            .r        (cr[j+1]),
            .y        (cy[j+1]),
            .s        (cs[j+1]),
            .k        (ck[j+1])
         );
      end

      always_comb begin
         kp1 = {1'b0, ck[NC]} + (KW+1)'(1);
         nx  = XW'(kp1[KW:1]);
         rx  = cc[NC].neg ? (-nx) : nx;
         res[i] = cc[NC].degen ? '0 : rx[OB-1:0];
      end
   end

   always_comb begin
      rsp_payload_in.normal_x   = res[0];
      rsp_payload_in.normal_y   = res[1];
      rsp_payload_in.normal_z   = res[2];
      rsp_payload_in.degenerate = g_lane[0].cc[NC].degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= g_lane[0].cc[NC].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
